/* rtl/uart_link_health_autobaud_assert.svh */
// Assertion macros shared by the link health monitor RTL.
`ifndef UART_LINK_HEALTH_AUTOBAUD_ASSERT_SVH
`define UART_LINK_HEALTH_AUTOBAUD_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ULH_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ULH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ulh_pkg.sv */
// Shared types and codes for the receive link health monitor.
`default_nettype none

package ulh_pkg;

  // Widths fixed by the register map and the channel fields
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int TIME_W     = 32;
  localparam int COUNT_W    = 8;
  localparam int RATE_OUT_W = 3;

  // Result status codes
  typedef enum logic [2:0] {
    ST_HEALTHY   = 3'd0,
    ST_ADAPTED   = 3'd1,
    ST_EXHAUSTED = 3'd2,
    ST_SILENT    = 3'd3,
    ST_NO_FIX    = 3'd4
  } status_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BAD_LIMIT      = 2'd0,
    REG_SILENT_TIMEOUT = 2'd1,
    REG_NO_FIX_TIMEOUT = 2'd2,
    REG_AUTOBAUD_EN    = 2'd3
  } cfg_reg_t;

  // Register reset values
  localparam logic [COUNT_W-1:0] BAD_LIMIT_RST      = 8'd8;
  localparam logic [TIME_W-1:0]  SILENT_TIMEOUT_RST = 32'd10000;
  localparam logic [TIME_W-1:0]  NO_FIX_TIMEOUT_RST = 32'd120000;

endpackage

`default_nettype wire

/* rtl/ulh_req_if.sv */
// Request channel: byte/frame events and health polls.
`default_nettype none

interface ulh_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic        frame_ok;
  logic [31:0] now_ms;

  modport source (output valid, output req_type, output frame_ok, output now_ms,
                  input ready);
  modport sink   (input valid, input req_type, input frame_ok, input now_ms,
                  output ready);
endinterface

`default_nettype wire

/* rtl/ulh_rsp_if.sv */
// Result channel: link status and selected rate per request.
`default_nettype none

interface ulh_rsp_if;
  import ulh_pkg::*;

  logic        valid;
  logic        ready;
  status_t     status;
  logic [2:0]  rate_index;
  logic        rate_changed;

  modport source (output valid, output status, output rate_index,
                  output rate_changed, input ready);
  modport sink   (input valid, input status, input rate_index,
                  input rate_changed, output ready);
endinterface

`default_nettype wire

/* rtl/uart_link_health_autobaud.sv */
// Receive link health monitor with automatic baud candidate search.
//
// Usage:
//  - req channel: one transfer per event. req_type 0 is a received frame
//    (frame_ok says whether it checked out), req_type 1 polls the health.
//    now_ms is the caller's free-running millisecond counter.
//  - rsp channel: exactly one result per request: status, the selected
//    candidate rate index after the event, and a rate-changed flag.
//  - cfg port: write-only, cfg_we/cfg_index/cfg_wdata, written while idle.
//  - Results are registered: output register, or skid entry while stalled.
//  - Throughput: one request per cycle while req.ready is high; all state
//    updates and the candidate priority search resolve in the accepting
//    cycle, so the state feedback loop sets that rate.
//  - Stall: a result register plus one skid entry; req.ready is low only
//    while the skid entry holds a result, so up to two results can wait.
//  - Reset (rst, synchronous): registers back to defaults, no byte seen,
//    no valid frame seen, rate 0, no candidate tried, channel empty.
`default_nettype none

`include "uart_link_health_autobaud_assert.svh"

module uart_link_health_autobaud #(
  parameter int NUM_RATES = 3
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [ulh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ulh_pkg::CFG_DATA_W-1:0] cfg_wdata,
  ulh_req_if.sink                            req,
  ulh_rsp_if.source                          rsp
);
  import ulh_pkg::*;

  localparam int RATE_W = (NUM_RATES > 1) ? $clog2(NUM_RATES) : 1;
  localparam int SUM_W  = RATE_W + 1;

  // Configuration registers
  logic [COUNT_W-1:0] bad_limit;
  logic [TIME_W-1:0]  silent_timeout_ms;
  logic [TIME_W-1:0]  no_fix_timeout_ms;
  logic               autobaud_enable;

  // Link state
  logic [TIME_W-1:0]    last_byte_time, last_byte_time_next;
  logic                 byte_seen, byte_seen_next;
  logic                 valid_seen, valid_seen_next;
  logic [TIME_W-1:0]    first_valid_time, first_valid_time_next;
  logic [COUNT_W-1:0]   bad_count, bad_count_next;
  logic [RATE_W-1:0]    current_rate, current_rate_next;
  logic [NUM_RATES-1:0] tried_mask, tried_mask_next;

  // Output register and skid entry
  logic            out_valid;
  status_t         out_status;
  logic [RATE_W-1:0] out_rate;
  logic            out_changed;
  logic            skid_valid;
  status_t         skid_status;
  logic [RATE_W-1:0] skid_rate;
  logic            skid_changed;

  // Per-request combinational results
  logic               in_xfer;
  logic               out_free;
  status_t            res_status;
  logic               res_changed;
  logic [COUNT_W-1:0] bad_inc;
  logic [TIME_W-1:0]  since_byte;
  logic [TIME_W-1:0]  since_valid;
  logic [NUM_RATES-1:0] marked;
  logic [SUM_W-1:0]   cand_sum;
  logic               cand_found;
  logic [RATE_W-1:0]  cand_rate;

  assign req.ready = !skid_valid;
  assign in_xfer   = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      bad_limit         <= BAD_LIMIT_RST;
      silent_timeout_ms <= SILENT_TIMEOUT_RST;
      no_fix_timeout_ms <= NO_FIX_TIMEOUT_RST;
      autobaud_enable   <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_BAD_LIMIT:      bad_limit         <= cfg_wdata[COUNT_W-1:0];
        REG_SILENT_TIMEOUT: silent_timeout_ms <= cfg_wdata[TIME_W-1:0];
        REG_NO_FIX_TIMEOUT: no_fix_timeout_ms <= cfg_wdata[TIME_W-1:0];
        REG_AUTOBAUD_EN:    autobaud_enable   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Next untried candidate in cyclic order after the current rate
  always_comb begin
    marked = tried_mask;
    marked[current_rate] = 1'b1;
    cand_found = 1'b0;
    cand_rate  = current_rate;
    cand_sum   = '0;
    for (int s = 1; s < NUM_RATES; s++) begin
      cand_sum = {1'b0, current_rate} + SUM_W'(s);
      if (cand_sum >= SUM_W'(NUM_RATES)) begin
        cand_sum = cand_sum - SUM_W'(NUM_RATES);
      end
      if (!cand_found && !marked[cand_sum[RATE_W-1:0]]) begin
        cand_found = 1'b1;
        cand_rate  = cand_sum[RATE_W-1:0];
      end
    end
  end

  // Event and poll handling
  always_comb begin
    last_byte_time_next   = last_byte_time;
    byte_seen_next        = byte_seen;
    valid_seen_next       = valid_seen;
    first_valid_time_next = first_valid_time;
    bad_count_next        = bad_count;
    current_rate_next     = current_rate;
    tried_mask_next       = tried_mask;
    res_status            = ST_HEALTHY;
    res_changed           = 1'b0;

    bad_inc     = (bad_count == '1) ? bad_count : bad_count + COUNT_W'(1);
    since_byte  = req.now_ms - last_byte_time;
    since_valid = req.now_ms - first_valid_time;

    if (!req.req_type) begin
      last_byte_time_next = req.now_ms;
      byte_seen_next      = 1'b1;
      if (req.frame_ok) begin
        bad_count_next = '0;
        if (!valid_seen) begin
          valid_seen_next       = 1'b1;
          first_valid_time_next = req.now_ms;
        end
      end else begin
        bad_count_next = bad_inc;
        if (bad_inc > bad_limit && autobaud_enable) begin
          if (cand_found) begin
            tried_mask_next   = marked | (NUM_RATES'(1) << cand_rate);
            current_rate_next = cand_rate;
            bad_count_next    = '0;
            res_changed       = 1'b1;
            res_status        = ST_ADAPTED;
          end else begin
            tried_mask_next = marked;
            res_status      = ST_EXHAUSTED;
          end
        end
      end
    end else begin
      if (!byte_seen || since_byte >= silent_timeout_ms) begin
        res_status = ST_SILENT;
      end else if (valid_seen && since_valid >= no_fix_timeout_ms) begin
        res_status = ST_NO_FIX;
      end
    end
  end

  // State update on each request transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      last_byte_time   <= '0;
      byte_seen        <= 1'b0;
      valid_seen       <= 1'b0;
      first_valid_time <= '0;
      bad_count        <= '0;
      current_rate     <= '0;
      tried_mask       <= '0;
    end else if (in_xfer) begin
      last_byte_time   <= last_byte_time_next;
      byte_seen        <= byte_seen_next;
      valid_seen       <= valid_seen_next;
      first_valid_time <= first_valid_time_next;
      bad_count        <= bad_count_next;
      current_rate     <= current_rate_next;
      tried_mask       <= tried_mask_next;
    end
  end

  // Output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || in_xfer;
      skid_valid <= 1'b0;
    end else if (in_xfer) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_status  <= skid_status;
        out_rate    <= skid_rate;
        out_changed <= skid_changed;
      end else begin
        out_status  <= res_status;
        out_rate    <= current_rate_next;
        out_changed <= res_changed;
      end
    end else if (in_xfer) begin
      skid_status  <= res_status;
      skid_rate    <= current_rate_next;
      skid_changed <= res_changed;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.rate_index   = RATE_OUT_W'(out_rate);
  assign rsp.rate_changed = out_changed;

  // Checks
  `ULH_ASSERT_NOW(a_skid_behind_out, clk, rst, skid_valid, out_valid,
                  "skid entry holds a result while output register is empty")
  `ULH_ASSERT_NOW(a_rate_in_range, clk, rst, 1'b1,
                  current_rate < RATE_W'(NUM_RATES - 1) ||
                  current_rate == RATE_W'(NUM_RATES - 1),
                  "selected rate beyond candidate list")
  `ULH_ASSERT_NEXT(a_rate_only_on_bad, clk, rst,
                   !(in_xfer && !req.req_type && !req.frame_ok),
                   $stable(current_rate),
                   "rate moved without a bad frame")
  `ULH_ASSERT_NEXT(a_tried_sticky, clk, rst, 1'b1,
                   ($past(tried_mask) & ~tried_mask) == '0,
                   "tried mark cleared outside reset")
  `ULH_ASSERT_NOW(a_changed_is_adapted, clk, rst, out_valid && out_changed,
                  out_status == ST_ADAPTED,
                  "rate change reported without adapted status")

endmodule

`default_nettype wire
